// ----- design/mrpt_pkg.sv -----
// shared constants, types and base tables for the word prime tester
package mrpt_pkg;

  localparam int WordBits = 64;
  localparam int ShiftBits = 7;
  localparam int BaseIdxBits = 3;

  typedef logic [WordBits-1:0] word_t;

  localparam logic [63:0] LimitSmall = 64'd1373653;
  localparam logic [63:0] LimitMid = 64'd4759123141;

  // base set selector codes
  typedef enum logic [1:0] {
    SET_SMALL = 2'd0,
    SET_MID   = 2'd1,
    SET_FULL  = 2'd2
  } base_set_t;

  // multiplier control from the sequencer
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t m;
  } mul_req_t;

  // multiplier status back to the sequencer
  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

  function automatic logic [2:0] num_bases(input base_set_t set);
    logic [2:0] n;
    unique case (set)
      SET_SMALL: n = 3'd2;
      SET_MID:   n = 3'd3;
      default:   n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] base_value(input base_set_t set,
                                             input logic [BaseIdxBits-1:0] idx);
    logic [31:0] v;
    v = 32'd2;
    unique case (set)
      SET_SMALL: v = (idx == 3'd0) ? 32'd2 : 32'd3;
      SET_MID: begin
        unique case (idx)
          3'd0:    v = 32'd2;
          3'd1:    v = 32'd7;
          default: v = 32'd61;
        endcase
      end
      default: begin
        unique case (idx)
          3'd0:    v = 32'd2;
          3'd1:    v = 32'd325;
          3'd2:    v = 32'd9375;
          3'd3:    v = 32'd28178;
          3'd4:    v = 32'd450775;
          3'd5:    v = 32'd9780504;
          default: v = 32'd1795265022;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

// ----- design/mrpt_mulmod.sv -----
// bit-serial modular multiplier: separate doubling and conditional add states
module mrpt_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  mrpt_pkg::mul_req_t req,
  output mrpt_pkg::mul_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_DBL, S_ADD} state_t;

  state_t state;
  mrpt_pkg::word_t acc, x, y, m;
  logic [mrpt_pkg::ShiftBits-1:0] cnt;
  logic [mrpt_pkg::WordBits:0] sum;
  mrpt_pkg::word_t addend, red;

  // shared adder: acc plus acc or x, reduced once by m
  always_comb begin
    addend = (state == S_DBL) ? acc : x;
    sum = {1'b0, acc} + {1'b0, addend};
    if (sum >= {1'b0, m}) red = mrpt_pkg::WordBits'(sum - {1'b0, m});
    else red = sum[mrpt_pkg::WordBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            acc <= '0;
            x <= req.x;
            y <= req.y;
            m <= req.m;
            cnt <= mrpt_pkg::ShiftBits'(mrpt_pkg::WordBits - 1);
            state <= S_DBL;
          end
        end
        S_DBL: begin
          acc <= red;
          if (y[cnt[5:0]]) state <= S_ADD;
          else if (cnt == '0) begin
            state <= S_IDLE;
            rsp.done <= 1'b1;
            rsp.prod <= red;
          end else cnt <= cnt - 1'b1;
        end
        S_ADD: begin
          acc <= red;
          if (cnt == '0) begin
            state <= S_IDLE;
            rsp.done <= 1'b1;
            rsp.prod <= red;
          end else begin
            cnt <= cnt - 1'b1;
            state <= S_DBL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/miller_rabin_word_prime_test_top.sv -----
// miller-rabin sequencer and handshake for one 64-bit word
//   channel | dir | signals
//   in      | in  | candidate_valid, candidate_ready, candidate
//   out     | out | is_prime_valid, is_prime_ready, is_prime
// a trivial word (below 4 or even) has its result registered as it is taken; otherwise
// each of the 2, 3 or 7 bases needs 64 squarings, one product per set bit of r
// and up to s-1 more squarings (at most about 127 products), and the products
// run one at a time on the one bit-serial modular multiplier.
// synchronous reset returns to idle; no new word is taken until the
// result register is emptied, and a stalled result holds.
module miller_rabin_word_prime_test_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        candidate_valid,
  output logic        candidate_ready,
  input  logic [63:0] candidate,
  output logic        is_prime_valid,
  input  logic        is_prime_ready,
  output logic        is_prime
);

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_REDB, S_PSQ, S_PMUL, S_CHECK, S_SQ, S_OUT
  } state_t;

  state_t state;
  mrpt_pkg::word_t a, r, x, b, am1;
  logic [mrpt_pkg::ShiftBits-1:0] s, k, bit_i;
  logic [mrpt_pkg::BaseIdxBits-1:0] bidx;
  mrpt_pkg::base_set_t bset;
  logic wait_mul;
  mrpt_pkg::mul_req_t req;
  mrpt_pkg::mul_rsp_t rsp;

  mrpt_mulmod u_mul (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign candidate_ready = (state == S_IDLE);
  assign am1 = a - 1'b1;

  // sequencer over bases, exponent bits and squarings
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_prime_valid <= 1'b0;
      req.start <= 1'b0;
      wait_mul <= 1'b0;
    end else begin
      req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (candidate_valid) begin
            a <= candidate;
            if (candidate <= 64'd3 || !candidate[0]) begin
              is_prime <= (candidate == 64'd2) || (candidate == 64'd3);
              is_prime_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              r <= candidate - 1'b1;
              s <= '0;
              bidx <= '0;
              if (candidate < mrpt_pkg::LimitSmall) bset <= mrpt_pkg::SET_SMALL;
              else if (candidate < mrpt_pkg::LimitMid) bset <= mrpt_pkg::SET_MID;
              else bset <= mrpt_pkg::SET_FULL;
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!r[0]) begin
            r <= r >> 1;
            s <= s + 1'b1;
          end else state <= S_BASE;
        end
        S_BASE: begin
          b <= 64'(mrpt_pkg::base_value(bset, bidx));
          state <= S_REDB;
        end
        S_REDB: begin
          // base is below 2^31; reduce by repeated subtraction
          if (b >= a) b <= b - a;
          else begin
            x <= (a == 64'd1) ? '0 : 64'd1;
            bit_i <= mrpt_pkg::ShiftBits'(mrpt_pkg::WordBits - 1);
            state <= S_PSQ;
            wait_mul <= 1'b0;
          end
        end
        S_PSQ: begin
          if (!wait_mul) begin
            req.start <= 1'b1;
            req.x <= x; req.y <= x; req.m <= a;
            wait_mul <= 1'b1;
          end else if (rsp.done) begin
            x <= rsp.prod;
            wait_mul <= 1'b0;
            if (r[bit_i[5:0]]) state <= S_PMUL;
            else if (bit_i == '0) state <= S_CHECK;
            else bit_i <= bit_i - 1'b1;
          end
        end
        S_PMUL: begin
          if (!wait_mul) begin
            req.start <= 1'b1;
            req.x <= b; req.y <= x; req.m <= a;
            wait_mul <= 1'b1;
          end else if (rsp.done) begin
            x <= rsp.prod;
            wait_mul <= 1'b0;
            if (bit_i == '0) state <= S_CHECK;
            else begin
              bit_i <= bit_i - 1'b1;
              state <= S_PSQ;
            end
          end
        end
        S_CHECK: begin
          k <= 7'd1;
          if (x == 64'd1 || x == am1) begin
            if (bidx == mrpt_pkg::num_bases(bset) - 1'b1) begin
              is_prime <= 1'b1; is_prime_valid <= 1'b1; state <= S_OUT;
            end else begin
              bidx <= bidx + 1'b1; state <= S_BASE;
            end
          end else state <= S_SQ;
        end
        S_SQ: begin
          if (k >= s) begin
            is_prime <= 1'b0; is_prime_valid <= 1'b1; state <= S_OUT;
          end else if (!wait_mul) begin
            req.start <= 1'b1;
            req.x <= x; req.y <= x; req.m <= a;
            wait_mul <= 1'b1;
          end else if (rsp.done) begin
            wait_mul <= 1'b0;
            x <= rsp.prod;
            k <= k + 1'b1;
            if (rsp.prod == am1) begin
              if (bidx == mrpt_pkg::num_bases(bset) - 1'b1) begin
                is_prime <= 1'b1; is_prime_valid <= 1'b1; state <= S_OUT;
              end else begin
                bidx <= bidx + 1'b1; state <= S_BASE;
              end
            end else if (rsp.prod == 64'd1) begin
              is_prime <= 1'b0; is_prime_valid <= 1'b1; state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (is_prime_ready) begin
            is_prime_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result valid only while holding a word
  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    is_prime_valid |-> state == S_OUT) else $error("result valid outside output state");
  // no word taken while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    is_prime_valid |-> !candidate_ready) else $error("ready while result pending");
  // multiplier only started from a multiply state
  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    req.start |-> $past(state == S_PSQ || state == S_PMUL || state == S_SQ))
    else $error("multiplier started outside multiply state");

endmodule
